// ===== rtl/core/sle_pkg.sv =====
// sle_pkg: sizes, codes, state encoding and control structs of the list engine
// no dependencies; imported by the store, the sequencer, the top level and the bench
`timescale 1ns / 1ps

package sle_pkg;

  // store geometry
  localparam int unsigned DEPTH = 128;
  localparam int unsigned DW    = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  // compare width that holds the entry count and the 8-bit position, plus one
  localparam int unsigned CMPW  = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_FIND
  } walk_op_t;

  // one read and one write port of the element store
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
  } mem_req_t;

  // finished result offered by the sequencer
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] found_position;
    logic [7:0] list_length;
  } res_t;

  // low 8 bits of a count-wide value
  function automatic logic [7:0] to_byte(input logic [CW-1:0] x);
    logic [CMPW-1:0] t;
    t = CMPW'(x);
    return t[7:0];
  endfunction

endpackage

// ===== rtl/core/sle_if.sv =====
// sle_in_if / sle_out_if: valid-ready channels for requests and results
// no dependencies; used by the top level, the sequencer and the bench
`timescale 1ns / 1ps

interface sle_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [7:0]        position;
  logic signed [31:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] found_position;
  logic [7:0] list_length;

  modport source (output valid, status, found_position, list_length, input ready);
  modport sink   (input valid, status, found_position, list_length, output ready);
endinterface

// ===== rtl/core/sle_mem.sv =====
// sle_mem: element store, one write and one registered read per cycle
// depends on sle_pkg for geometry and the port struct
`timescale 1ns / 1ps

module sle_mem import sle_pkg::*; (
  input  logic          clk,
  input  mem_req_t      req,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// sle_ctrl: request decode, entry count and the walk sequencer over the store
// depends on sle_pkg, sle_if; drives the port of sle_mem
`timescale 1ns / 1ps

module sle_ctrl import sle_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sle_in_if.sink        in_req,
  input  logic          res_taken,
  output res_t          res,
  output mem_req_t      mem_req,
  input  logic [DW-1:0] rd_data
);

  state_t        state_r, state_nxt;
  walk_op_t      op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] key_r, key_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] stop_r, stop_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] place_r, place_nxt;
  logic          more_r, more_nxt;
  logic          pend_r, pend_nxt;
  status_t       status_r, status_nxt;
  logic [7:0]    found_r, found_nxt;

  logic            accept;
  logic [CMPW-1:0] pos_e, n_e, pos_dec;
  logic [CW-1:0]   cnt_dec;
  logic [AW-1:0]   last_addr, pos_addr, pos_addr_raw;
  logic            full, pos_zero, ins_bad, del_bad, ins_walk, del_walk, match;

  assign in_req.ready = (state_r == S_IDLE);

  assign accept       = in_req.valid && in_req.ready;
  assign pos_e        = CMPW'(in_req.position);
  assign n_e          = CMPW'(cnt_r);
  assign pos_dec      = pos_e - 1'b1;
  assign cnt_dec      = cnt_r - 1'b1;
  assign last_addr    = cnt_dec[AW-1:0];
  assign pos_addr     = pos_dec[AW-1:0];
  assign pos_addr_raw = pos_e[AW-1:0];
  assign full         = (cnt_r == CW'(DEPTH));
  assign pos_zero     = (in_req.position == 8'd0);
  assign ins_bad      = pos_zero || (pos_e > n_e + 1'b1);
  assign del_bad      = pos_zero || (pos_e > n_e);
  assign ins_walk     = (pos_e <= n_e);
  assign del_walk     = (pos_e < n_e);
  assign match        = pend_r && (rd_data == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_req.mode))
            MODE_APPEND: state_nxt = S_DONE;
            MODE_INSERT: begin
              if (ins_bad || full) state_nxt = S_DONE;
              else if (ins_walk)   state_nxt = S_WALK;
              else                 state_nxt = S_PLACE;
            end
            MODE_DELETE: state_nxt = (del_bad || !del_walk) ? S_DONE : S_WALK;
            MODE_FIND:   state_nxt = (cnt_r == '0) ? S_DONE : S_WALK;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (op_r == OP_FIND) begin
          if (match || !more_r) state_nxt = S_DONE;
        end else if (!more_r) begin
          state_nxt = (op_r == OP_INS) ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: state_nxt = S_DONE;
      S_DONE:  if (res_taken) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and store port
  always_comb begin
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    stop_nxt   = stop_r;
    prev_nxt   = prev_r;
    place_nxt  = place_r;
    more_nxt   = more_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    found_nxt  = found_r;

    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = idx_r;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = place_r;
    mem_req.wr_data = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt    = in_req.value;
          found_nxt  = 8'd0;
          status_nxt = ST_OK;
          more_nxt   = 1'b1;
          pend_nxt   = 1'b0;
          place_nxt  = pos_addr;
          unique case (mode_t'(in_req.mode))
            MODE_APPEND: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_r[AW-1:0];
                mem_req.wr_data = in_req.value;
                cnt_nxt         = cnt_r + 1'b1;
              end
            end
            MODE_INSERT: begin
              if (ins_bad)   status_nxt = ST_BADPOS;
              else if (full) status_nxt = ST_FULL;
              op_nxt   = OP_INS;
              idx_nxt  = last_addr;
              stop_nxt = pos_addr;
            end
            MODE_DELETE: begin
              op_nxt   = OP_DEL;
              idx_nxt  = pos_addr_raw;
              stop_nxt = last_addr;
              if (del_bad)        status_nxt = ST_BADPOS;
              else if (!del_walk) cnt_nxt    = cnt_dec;
            end
            MODE_FIND: begin
              op_nxt   = OP_FIND;
              idx_nxt  = '0;
              stop_nxt = last_addr;
              if (cnt_r == '0) status_nxt = ST_NOTFOUND;
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_WALK: begin
        // issue the next read while the previous read is written back
        if (more_r) begin
          mem_req.rd_en = 1'b1;
          prev_nxt      = idx_r;
          pend_nxt      = 1'b1;
          if (idx_r == stop_r)    more_nxt = 1'b0;
          else if (op_r == OP_INS) idx_nxt = idx_r - 1'b1;
          else                     idx_nxt = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          case (op_r)
            OP_INS: begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = prev_r + 1'b1;
            end
            OP_DEL: begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = prev_r - 1'b1;
            end
            OP_FIND: begin
              if (match)        found_nxt  = to_byte(CW'(prev_r) + 1'b1);
              else if (!more_r) status_nxt = ST_NOTFOUND;
            end
            default: found_nxt = found_r;
          endcase
        end
        if (op_r == OP_DEL && !more_r) cnt_nxt = cnt_dec;
      end
      S_PLACE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = place_r;
        mem_req.wr_data = key_r;
        cnt_nxt         = cnt_r + 1'b1;
      end
      S_DONE: begin
        pend_nxt = 1'b0;
      end
      default: pend_nxt = 1'b0;
    endcase
  end

  assign res.valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.found_position = found_r;
  assign res.list_length    = to_byte(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    stop_r   <= stop_nxt;
    prev_r   <= prev_nxt;
    place_r  <= place_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

endmodule

// ===== rtl/core/sequential_list_engine.sv =====
// sequential_list_engine: top level, sequencer, element store and result register
// depends on sle_pkg, sle_if, sle_mem, sle_ctrl
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to DEPTH (128) signed 32-bit values
// in a single-port-read, single-port-write store, with its length in a
// register that reset clears; the store itself is never cleared, and only
// entries below the length are ever read. Each request is append, insert at
// a 1-based position, delete at a position, or find the first entry equal
// to a key, and each request returns exactly one result with a status
// (ok, full, bad position, not found), the position of a find hit and the
// new length. One request is worked at a time: in_req.ready is high only
// while the sequencer is idle. The sequencer walks the store one entry per
// cycle, reading the next entry while it writes back the one read before,
// so the store's single read and single write port set the rate. Append,
// every rejected request and a delete of the last entry go straight to the
// result; insert walks from the last entry down to position p and then
// places the value (no walk when it lands past the last entry), delete
// walks from p+1 to the last entry, find from the first to a hit or the end.
// A finished result sits in an output register, so the engine takes the
// next request while the previous result still waits on out_res.ready.
module sequential_list_engine import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sle_in_if.sink     in_req,
  sle_out_if.source  out_res
);

  // sequencer to store and to the result register
  mem_req_t      mem_req;
  logic [DW-1:0] rd_data;
  res_t          res;
  logic          res_taken;

  // result register
  logic       out_valid_r, out_valid_nxt;
  status_t    status_r, status_nxt;
  logic [7:0] found_r, found_nxt;
  logic [7:0] length_r, length_nxt;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .res_taken (res_taken),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  sle_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // result moves into the output register once it is empty or being drained
  assign res_taken = res.valid && (!out_valid_r || out_res.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    length_nxt    = length_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_taken) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res.status;
      found_nxt     = res.found_position;
      length_nxt    = res.list_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
    length_r <= length_nxt;
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = status_r;
  assign out_res.found_position = found_r;
  assign out_res.list_length    = length_r;

`ifndef SYNTHESIS
  // an accepted request closes the input until its result is handed over
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while sequencer busy");

  // a finished result never coexists with an open input
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !res.valid)
    else $error("result pending while idle");

  // only a successful find carries a position
  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status != ST_OK) |-> (res.found_position == 8'd0))
    else $error("position reported on a failed request");

  // the store is never written and read at the same address in one cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("store read and write collide");
`endif

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for sequential_list_engine, with a list predictor,
// a queue-fed request driver and a result monitor; depends on sle_pkg, sle_if
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  // one queued request
  typedef struct {
    mode_t              mode;
    logic [7:0]         position;
    logic signed [31:0] value;
  } list_req_t;

  // one predicted result
  typedef struct {
    status_t    status;
    logic [7:0] found_position;
    logic [7:0] list_length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sle_in_if  in_req ();
  sle_out_if out_res ();

  sequential_list_engine u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #1 clk = ~clk;

  // shadow copy of the list, advanced at each accepted request
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_len = 0;

  list_req_t          pending_reqs [$];
  list_result_t       expected_results [$];
  logic signed [31:0] value_pool [$];

  // length the generator assumes, so it can steer toward full and empty
  int gen_len = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  req_taken      = 1'b0;

  int  mismatches   = 0;
  int  results_seen = 0;
  int  reqs_taken   = 0;
  int  longest_list = 0;
  int  status_seen [4] = '{default: 0};

  // list behavior: apply one request to the shadow list, return its result
  function automatic list_result_t list_apply(mode_t m, logic [7:0] pos,
                                              logic signed [31:0] val);
    list_result_t r;
    int p;
    int i;
    p = pos;
    r.status = ST_OK;
    r.found_position = 8'd0;
    case (m)
      MODE_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      MODE_INSERT: begin
        // position check wins over the full check
        if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: begin
        // first match wins
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val) begin
            r.status = ST_OK;
            r.found_position = 8'(i + 1);
            break;
          end
        end
      end
    endcase
    r.list_length = 8'(shadow_len);
    return r;
  endfunction

  // queue a request and track the length the generator expects
  task automatic push_req(mode_t m, int pos, logic signed [31:0] val);
    list_req_t q;
    int p;
    q.mode = m;
    q.position = 8'(pos);
    q.value = val;
    p = q.position;
    pending_reqs.push_back(q);
    case (m)
      MODE_APPEND: if (gen_len < DEPTH) gen_len++;
      MODE_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
      MODE_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
      default: ;
    endcase
    if (m == MODE_APPEND || m == MODE_INSERT) begin
      value_pool.push_back(val);
      if (value_pool.size() > 64) void'(value_pool.pop_front());
    end
  endtask

  // mix of wide random, small clustered (duplicates), extremes and reuse
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    int r;
    r = $urandom_range(0, 9);
    v = $urandom;
    if (r >= 4 && r < 6) begin
      v = $signed(32'($urandom_range(0, 7))) - 4;
    end else if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end else if (r >= 7 && value_pool.size() > 0) begin
      v = value_pool[$urandom_range(0, value_pool.size() - 1)];
    end
    return v;
  endfunction

  // find keys lean on values already stored, so hits are common
  function automatic logic signed [31:0] pick_key();
    if (value_pool.size() > 0 && $urandom_range(0, 9) < 6)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return pick_value();
  endfunction

  function automatic int pick_ins_pos();
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return gen_len + 1;
      default: return $urandom_range(1, gen_len + 1);
    endcase
  endfunction

  function automatic int pick_del_pos();
    if (gen_len == 0) return 1;
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return gen_len;
      default: return $urandom_range(1, gen_len);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_req.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // random traffic: grow toward a target length, then drain back to empty;
  // deep phases fill the whole store and try the full-list rejections
  task automatic run_phase(int send_pct, int stall_pct, int budget, bit deep);
    int  n;
    int  r;
    int  top;
    bit  growing;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    growing = 1'b1;
    top = deep ? DEPTH : $urandom_range(4, 30);
    while (n < budget) begin
      if (growing && gen_len >= top) begin
        if (top == DEPTH) begin
          // full list: append, valid insert, insert past the end, find
          push_req(MODE_APPEND, $urandom_range(0, 255), pick_value());
          push_req(MODE_INSERT, pick_ins_pos(), pick_value());
          push_req(MODE_INSERT, gen_len + 2, pick_value());
          push_req(MODE_FIND, $urandom_range(0, 255), pick_key());
          n += 4;
        end
        growing = 1'b0;
      end else if (!growing && gen_len == 0) begin
        growing = 1'b1;
        if (!deep) top = $urandom_range(4, 30);
      end
      r = $urandom_range(0, 99);
      if (r >= 96) begin
        // noise: any mode, any position
        push_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 255), pick_value());
      end else if (growing) begin
        if (r < 45)      push_req(MODE_APPEND, $urandom_range(0, 255), pick_value());
        else if (r < 80) push_req(MODE_INSERT, pick_ins_pos(), pick_value());
        else if (r < 92) push_req(MODE_FIND, $urandom_range(0, 255), pick_key());
        else             push_req(MODE_DELETE, pick_del_pos(), pick_value());
      end else begin
        if (r < 80)      push_req(MODE_DELETE, pick_del_pos(), pick_value());
        else if (r < 92) push_req(MODE_FIND, $urandom_range(0, 255), pick_key());
        else             push_req(MODE_APPEND, $urandom_range(0, 255), pick_value());
      end
      n++;
    end
    wait_drained();
  endtask

  // request driver: inputs change on the falling edge; a request is held
  // until the monitor has seen it taken, then the next one may follow at once
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_req.valid || req_taken) begin
        req_taken = 1'b0;
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req.valid    <= 1'b1;
          in_req.mode     <= pending_reqs[0].mode;
          in_req.position <= pending_reqs[0].position;
          in_req.value    <= pending_reqs[0].value;
          void'(pending_reqs.pop_front());
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stalls at random
  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: check the result first, then predict the request taken this edge
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d found %0d length %0d",
                     out_res.status, out_res.found_position, out_res.list_length);
        end else begin
          want = expected_results.pop_front();
          if (out_res.status !== want.status ||
              out_res.found_position !== want.found_position ||
              out_res.list_length !== want.list_length) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result %0d: expected status %0d found %0d length %0d",
                       results_seen, want.status, want.found_position, want.list_length);
              $display("  got status %0d found %0d length %0d",
                       out_res.status, out_res.found_position, out_res.list_length);
            end
          end
          if (out_res.status === want.status) status_seen[want.status]++;
        end
      end
      if (in_req.valid && in_req.ready) begin
        req_taken = 1'b1;
        reqs_taken++;
        expected_results.push_back(list_apply(mode_t'(in_req.mode), in_req.position,
                                              in_req.value));
        if (shadow_len > longest_list) longest_list = shadow_len;
      end
    end
  end

  // generous limit for the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", expected_results.size());
    $display("[sequential_list_engine] ERROR");
    $finish;
  end

  initial begin
    in_req.valid    = 1'b0;
    in_req.mode     = MODE_APPEND;
    in_req.position = 8'd0;
    in_req.value    = 32'sd0;
    out_res.ready   = 1'b0;
    rst_n           = 1'b0;

    // directed: empty-list rejections, position bounds, extremes, first match
    push_req(MODE_FIND, 0, 32'sd0);
    push_req(MODE_DELETE, 1, 32'sd0);
    push_req(MODE_DELETE, 0, 32'sd0);
    push_req(MODE_INSERT, 0, 32'sd5);
    push_req(MODE_INSERT, 2, 32'sd5);
    push_req(MODE_INSERT, 1, 32'h7fff_ffff);
    push_req(MODE_APPEND, 0, 32'h8000_0000);
    push_req(MODE_INSERT, 3, 32'sd0);
    push_req(MODE_INSERT, 1, 32'hffff_ffff);
    push_req(MODE_INSERT, 255, 32'sd9);
    push_req(MODE_FIND, 0, 32'h8000_0000);
    push_req(MODE_FIND, 128, 32'hffff_ffff);
    push_req(MODE_APPEND, 0, 32'h7fff_ffff);
    push_req(MODE_FIND, 0, 32'h7fff_ffff);
    push_req(MODE_FIND, 0, 32'sd12345);
    push_req(MODE_DELETE, 6, 32'sd0);
    push_req(MODE_DELETE, 5, 32'sd0);
    push_req(MODE_DELETE, 1, 32'sd0);
    push_req(MODE_DELETE, 2, 32'sd0);
    push_req(MODE_DELETE, 255, 32'hffff_ffff);
    push_req(MODE_APPEND, 255, 32'h5a5a_5a5a);
    push_req(MODE_FIND, 255, 32'h5a5a_5a5a);
    push_req(MODE_INSERT, 128, 32'sd1);

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait_drained();

    // idling phases: none, sender idle, receiver stalls, both lightly
    run_phase(0, 0, 330, 1'b1);
    run_phase(82, 0, 100, 1'b0);
    run_phase(0, 82, 100, 1'b0);
    run_phase(12, 12, 300, 1'b1);

    // let any stray late result show up
    repeat (140) @(posedge clk);

    $display("ran %0d requests in four idling phases, longest list %0d of %0d",
             reqs_taken, longest_list, DEPTH);
    $display("ok %0d, full %0d, bad position %0d, not found %0d, mismatches %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_NOTFOUND], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[sequential_list_engine] OK");
    end else begin
      $display("[sequential_list_engine] ERROR");
    end
    $finish;
  end

endmodule
